FILE: src/defp_pkg.sv
package defp_pkg;

    localparam logic [15:0] START_MARK = 16'hBAAB;
    localparam logic [15:0] END_MARK   = 16'hFEEF;
    localparam logic [15:0] PAD_WORD   = 16'h8000;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CHAN,
        PH_TIME_HI,
        PH_TIME_LO,
        PH_FINE,
        PH_ENERGY,
        PH_CHECK,
        PH_END
    } t_phase;

    typedef enum logic [1:0] {
        ST_GOOD        = 2'd0,
        ST_CHECK_ERR   = 2'd1,
        ST_FLAGGED     = 2'd2,
        ST_MISSING_END = 2'd3
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [14:0] channel;
        logic [27:0] hit_time;
        logic [5:0]  hit_time_fine;
        logic [5:0]  pulse_width;
        logic [4:0]  pulse_width_fine;
        logic [14:0] energy;
    } t_result;

endpackage

FILE: src/defp_decoder.sv
module defp_decoder
    import defp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [15:0] i_word,
    output logic        o_res_valid,
    output t_result     o_res
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_check, n_check;
    logic [15:0] r_recv, n_recv;
    logic [14:0] r_channel, n_channel;
    logic [27:0] r_time, n_time;
    logic [5:0]  r_time_fine, n_time_fine;
    logic [5:0]  r_width, n_width;
    logic [4:0]  r_width_fine, n_width_fine;
    logic [14:0] r_energy, n_energy;

    logic w_pad;
    logic w_flag;
    logic w_start;
    logic w_end;
    logic w_body;

    assign w_pad   = (i_word == PAD_WORD);
    assign w_flag  = i_word[15];
    assign w_start = (i_word == START_MARK);
    assign w_end   = (i_word == END_MARK);
    assign w_body  = (r_phase != PH_IDLE) && (r_phase != PH_END);

    always_comb begin
        n_phase = r_phase;
        if (i_fire && !w_pad) begin
            unique case (r_phase)
                PH_IDLE:    n_phase = w_start ? PH_CHAN : PH_IDLE;
                PH_CHAN:    n_phase = w_flag ? (w_start ? PH_CHAN : PH_IDLE) : PH_TIME_HI;
                PH_TIME_HI: n_phase = w_flag ? (w_start ? PH_CHAN : PH_IDLE) : PH_TIME_LO;
                PH_TIME_LO: n_phase = w_flag ? (w_start ? PH_CHAN : PH_IDLE) : PH_FINE;
                PH_FINE:    n_phase = w_flag ? (w_start ? PH_CHAN : PH_IDLE) : PH_ENERGY;
                PH_ENERGY:  n_phase = w_flag ? (w_start ? PH_CHAN : PH_IDLE) : PH_CHECK;
                PH_CHECK:   n_phase = w_flag ? (w_start ? PH_CHAN : PH_IDLE) : PH_END;
                PH_END:     n_phase = w_end ? PH_IDLE : (w_start ? PH_CHAN : PH_IDLE);
                default:    n_phase = PH_IDLE;
            endcase
        end
    end

    always_comb begin
        n_check      = r_check;
        n_recv       = r_recv;
        n_channel    = r_channel;
        n_time       = r_time;
        n_time_fine  = r_time_fine;
        n_width      = r_width;
        n_width_fine = r_width_fine;
        n_energy     = r_energy;
        o_res_valid  = 1'b0;
        o_res        = '0;
        if (i_fire && !w_pad) begin
            if ((w_body && w_flag) || (r_phase == PH_END && !w_end)) begin
                o_res_valid = 1'b1;
                o_res.status = (r_phase == PH_END) ? ST_MISSING_END : ST_FLAGGED;
                if (w_start) begin
                    n_check = i_word;
                end
            end else begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if (w_start) begin
                            n_check = i_word;
                        end
                    end
                    PH_CHAN: begin
                        n_channel = i_word[14:0];
                        n_check   = r_check ^ i_word;
                    end
                    PH_TIME_HI: begin
                        n_time  = {i_word[14:0], 13'd0};
                        n_check = r_check ^ i_word;
                    end
                    PH_TIME_LO: begin
                        n_time      = {r_time[27:13], i_word[14:2]};
                        n_time_fine = {1'b0, i_word[1:0], 3'd0};
                        n_check     = r_check ^ i_word;
                    end
                    PH_FINE: begin
                        n_time_fine  = r_time_fine + {2'd0, i_word[14:11]};
                        n_width      = i_word[10:5];
                        n_width_fine = i_word[4:0];
                        n_check      = r_check ^ i_word;
                    end
                    PH_ENERGY: begin
                        n_energy = i_word[14:0];
                        n_check  = r_check ^ i_word;
                    end
                    PH_CHECK: begin
                        n_recv = i_word;
                    end
                    PH_END: begin
                        o_res_valid            = 1'b1;
                        o_res.status           = ((r_check ^ i_word) == r_recv)
                                                 ? ST_GOOD : ST_CHECK_ERR;
                        o_res.channel          = r_channel;
                        o_res.hit_time         = r_time;
                        o_res.hit_time_fine    = r_time_fine;
                        o_res.pulse_width      = r_width;
                        o_res.pulse_width_fine = r_width_fine;
                        o_res.energy           = r_energy;
                    end
                    default: begin
                        n_check = r_check;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_check      <= n_check;
        r_recv       <= n_recv;
        r_channel    <= n_channel;
        r_time       <= n_time;
        r_time_fine  <= n_time_fine;
        r_width      <= n_width;
        r_width_fine <= n_width_fine;
        r_energy     <= n_energy;
    end

    a_res_needs_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_fire)
        else $error("result produced without a processed word");

    a_flag_only_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == ST_FLAGGED) |-> w_body)
        else $error("flagged-word error outside the frame body");

    a_pad_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_pad) |=> (r_phase == $past(r_phase)))
        else $error("padding word changed the frame phase");

endmodule

FILE: src/detector_event_frame_parser_core.sv
// Detector event frame parser.
// Input channel: i_valid / o_stall carry one 16-bit stream word in i_word.
// A word is taken at a rising edge where i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall carry one decoded frame result: status,
// channel, hit time, fine time, pulse width, fine width and energy.
// A result is taken at a rising edge where o_valid is high and i_stall is low.
// A word that closes or breaks a frame presents its result on the output
// register; all other words produce nothing. Throughput is one word per
// cycle while the receiver does not stall. The input register feeds the frame
// decoder, whose result lands in the output register in the next cycle.
// When the receiver stalls, the result holds, the input register still
// accepts one more word, and o_stall rises only when both registers are full.
// Reset is synchronous on i_rst_n, active low; it empties both registers
// and returns the decoder to waiting for a start marker.
module detector_event_frame_parser_core
    import defp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [14:0] o_channel,
    output logic [27:0] o_hit_time,
    output logic [5:0]  o_hit_time_fine,
    output logic [5:0]  o_pulse_width,
    output logic [4:0]  o_pulse_width_fine,
    output logic [14:0] o_energy
);

    logic        r_in_valid;
    logic [15:0] r_in_word;
    logic        r_out_valid;
    t_result     r_out;

    logic        w_adv;
    logic        w_fire;
    logic        w_res_valid;
    t_result     w_res;

    assign w_adv   = !r_out_valid || !i_stall;
    assign w_fire  = r_in_valid && w_adv;
    assign o_stall = r_in_valid && !w_adv;

    defp_decoder u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_word      (r_in_word),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= w_res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_word <= i_word;
        end
        if (w_adv && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_out.status;
    assign o_channel          = r_out.channel;
    assign o_hit_time         = r_out.hit_time;
    assign o_hit_time_fine    = r_out.hit_time_fine;
    assign o_pulse_width      = r_out.pulse_width;
    assign o_pulse_width_fine = r_out.pulse_width_fine;
    assign o_energy           = r_out.energy;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled while the pipeline could move");

    a_error_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_out.status == ST_FLAGGED || r_out.status == ST_MISSING_END))
        |-> (o_channel == '0 && o_hit_time == '0 && o_energy == '0))
        else $error("error result carries frame fields");

    a_fine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit_time_fine <= 6'd39))
        else $error("fine time out of range");

endmodule

FILE: test/detector_event_frame_parser_checker.sv
`timescale 1ns / 100ps

module detector_event_frame_parser_checker
    import defp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_word_valid,
    input  logic        i_word_stall,
    input  logic [15:0] i_word,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic [1:0]  i_status,
    input  logic [14:0] i_channel,
    input  logic [27:0] i_hit_time,
    input  logic [5:0]  i_hit_time_fine,
    input  logic [5:0]  i_pulse_width,
    input  logic [4:0]  i_pulse_width_fine,
    input  logic [14:0] i_energy,
    output int          o_mismatches,
    output int          o_outstanding
);

    t_phase      phase;
    logic [15:0] run_check;
    logic [15:0] rx_check;
    logic [14:0] held_channel;
    logic [27:0] held_time;
    logic [5:0]  held_time_fine;
    logic [5:0]  held_width;
    logic [4:0]  held_width_fine;
    logic [14:0] held_energy;

    t_result     due_results[$];
    int          mismatches;

    initial begin
        o_mismatches = 0;
        o_outstanding = 0;
        mismatches = 0;
    end

    task automatic clear_frame_state();
        phase = PH_IDLE;
        run_check = '0;
        rx_check = '0;
        held_channel = '0;
        held_time = '0;
        held_time_fine = '0;
        held_width = '0;
        held_width_fine = '0;
        held_energy = '0;
    endtask

    task automatic resync(input logic [15:0] w);
        if (w == START_MARK) begin
            run_check = w;
            phase = PH_CHAN;
        end else begin
            phase = PH_IDLE;
        end
    endtask

    task automatic parse_word(input logic [15:0] w);
        t_result r;
        r = '0;
        if (w == PAD_WORD) begin
            return;
        end
        if (phase != PH_IDLE && phase != PH_END && w[15]) begin
            r.status = ST_FLAGGED;
            due_results.push_back(r);
            resync(w);
            return;
        end
        case (phase)
            PH_CHAN: begin
                held_channel = w[14:0];
                run_check = run_check ^ w;
                phase = PH_TIME_HI;
            end
            PH_TIME_HI: begin
                held_time = {w[14:0], 13'd0};
                run_check = run_check ^ w;
                phase = PH_TIME_LO;
            end
            PH_TIME_LO: begin
                held_time = held_time + 28'(w >> 2);
                held_time_fine = {1'b0, w[1:0], 3'd0};
                run_check = run_check ^ w;
                phase = PH_FINE;
            end
            PH_FINE: begin
                held_time_fine = held_time_fine + {1'b0, w[15:11]};
                held_width = w[10:5];
                held_width_fine = w[4:0];
                run_check = run_check ^ w;
                phase = PH_ENERGY;
            end
            PH_ENERGY: begin
                held_energy = w[14:0];
                run_check = run_check ^ w;
                phase = PH_CHECK;
            end
            PH_CHECK: begin
                rx_check = w;
                phase = PH_END;
            end
            PH_END: begin
                if (w != END_MARK) begin
                    r.status = ST_MISSING_END;
                    due_results.push_back(r);
                    resync(w);
                end else begin
                    run_check = run_check ^ w;
                    r.status = (run_check == rx_check) ? ST_GOOD : ST_CHECK_ERR;
                    r.channel = held_channel;
                    r.hit_time = held_time;
                    r.hit_time_fine = held_time_fine;
                    r.pulse_width = held_width;
                    r.pulse_width_fine = held_width_fine;
                    r.energy = held_energy;
                    due_results.push_back(r);
                    phase = PH_IDLE;
                end
            end
            default: begin
                resync(w);
            end
        endcase
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got.status = t_status'(i_status);
        got.channel = i_channel;
        got.hit_time = i_hit_time;
        got.hit_time_fine = i_hit_time_fine;
        got.pulse_width = i_pulse_width;
        got.pulse_width_fine = i_pulse_width_fine;
        got.energy = i_energy;
        if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: unexpected result status %0d channel %h time %h", $realtime,
                         i_status, i_channel, i_hit_time);
            end
            return;
        end
        want = due_results.pop_front();
        if (got.status !== want.status || got.channel !== want.channel
                || got.hit_time !== want.hit_time
                || got.hit_time_fine !== want.hit_time_fine
                || got.pulse_width !== want.pulse_width
                || got.pulse_width_fine !== want.pulse_width_fine
                || got.energy !== want.energy) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: expected st %0d ch %h t %h tf %h w %h wf %h e %h", $realtime,
                         want.status, want.channel, want.hit_time, want.hit_time_fine,
                         want.pulse_width, want.pulse_width_fine, want.energy);
                $display("%0t: actual   st %0d ch %h t %h tf %h w %h wf %h e %h", $realtime,
                         got.status, got.channel, got.hit_time, got.hit_time_fine,
                         got.pulse_width, got.pulse_width_fine, got.energy);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame_state();
            due_results.delete();
        end else begin
            if (i_word_valid && !i_word_stall) begin
                parse_word(i_word);
            end
            if (i_res_valid && !i_res_stall) begin
                check_result();
            end
        end
        o_mismatches <= mismatches;
        o_outstanding <= due_results.size();
    end

endmodule

FILE: test/detector_event_frame_parser_core_tb.sv
`timescale 1ns / 100ps

module detector_event_frame_parser_core_tb;
    import defp_pkg::*;

    typedef enum int {
        FRAME_CLEAN,
        FRAME_BAD_CHECK,
        FRAME_FLAGGED,
        FRAME_NO_END
    } t_fault;

    localparam int WORD_TARGET = 800;
    localparam int QUIET_TAIL  = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [15:0] i_word = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [14:0] o_channel;
    logic [27:0] o_hit_time;
    logic [5:0]  o_hit_time_fine;
    logic [5:0]  o_pulse_width;
    logic [4:0]  o_pulse_width_fine;
    logic [14:0] o_energy;

    int mismatches;
    int outstanding;
    int words_sent = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int stall_left = 0;
    int frames;

    detector_event_frame_parser_core DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_word             (i_word),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_channel          (o_channel),
        .o_hit_time         (o_hit_time),
        .o_hit_time_fine    (o_hit_time_fine),
        .o_pulse_width      (o_pulse_width),
        .o_pulse_width_fine (o_pulse_width_fine),
        .o_energy           (o_energy)
    );

    detector_event_frame_parser_checker checker_inst (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_word_valid       (i_valid),
        .i_word_stall       (o_stall),
        .i_word             (i_word),
        .i_res_valid        (o_valid),
        .i_res_stall        (i_stall),
        .i_status           (o_status),
        .i_channel          (o_channel),
        .i_hit_time         (o_hit_time),
        .i_hit_time_fine    (o_hit_time_fine),
        .i_pulse_width      (o_pulse_width),
        .i_pulse_width_fine (o_pulse_width_fine),
        .i_energy           (o_energy),
        .o_mismatches       (mismatches),
        .o_outstanding      (outstanding)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || stall_pct == 0) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            i_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(1, 100) <= stall_pct) begin
            i_stall <= 1'b1;
            stall_left <= $urandom_range(0, 16);
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send_word(input logic [15:0] w);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic send_frame(input logic [14:0] ch, input logic [14:0] th,
                              input logic [14:0] tl, input logic [14:0] fw,
                              input logic [14:0] en, input t_fault fault,
                              input int spot, input logic [15:0] odd, input int pad_pct);
        logic [15:0] w [0:7];
        int i;
        w[0] = START_MARK;
        w[1] = {1'b0, ch};
        w[2] = {1'b0, th};
        w[3] = {1'b0, tl};
        w[4] = {1'b0, fw};
        w[5] = {1'b0, en};
        w[7] = END_MARK;
        w[6] = w[0] ^ w[1] ^ w[2] ^ w[3] ^ w[4] ^ w[5] ^ w[7];
        if (fault == FRAME_BAD_CHECK) begin
            w[6] = w[6] ^ (16'd1 << $urandom_range(0, 14));
        end
        for (i = 0; i < 8; i++) begin
            if (pad_pct != 0 && $urandom_range(1, 100) <= pad_pct) begin
                send_word(PAD_WORD);
            end
            if (fault == FRAME_FLAGGED && i == spot) begin
                send_word(odd);
                return;
            end
            if (fault == FRAME_NO_END && i == 7) begin
                send_word(odd);
            end else begin
                send_word(w[i]);
            end
        end
    endtask

    function automatic logic [14:0] body_value();
        case ($urandom_range(0, 7))
            0: return 15'h0000;
            1: return 15'h7FFF;
            default: return 15'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic logic [15:0] flagged_word();
        logic [15:0] w;
        if ($urandom_range(0, 3) == 0) begin
            return START_MARK;
        end
        w = 16'($urandom_range(0, 65535)) | 16'h8000;
        return (w == PAD_WORD) ? 16'hFFFF : w;
    endfunction

    function automatic logic [15:0] wrong_end_word();
        logic [15:0] w;
        if ($urandom_range(0, 3) == 0) begin
            return START_MARK;
        end
        w = 16'($urandom_range(0, 65535));
        return (w == END_MARK || w == PAD_WORD) ? 16'h0000 : w;
    endfunction

    initial begin
        t_fault fault;
        int pick;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(16'h1234);
        send_frame(15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, FRAME_CLEAN, 0, 0, 25);
        send_frame(15'h0000, 15'h0000, 15'h0000, 15'h0000, 15'h0000, FRAME_BAD_CHECK, 0, 0, 0);
        send_frame(15'h1234, 15'h5678, 15'h0003, 15'h7800, 15'h0ABC, FRAME_FLAGGED, 3,
                   START_MARK, 0);
        send_frame(15'h0001, 15'h4000, 15'h7FFC, 15'h07E0, 15'h001F, FRAME_NO_END, 0,
                   START_MARK, 0);
        send_frame(15'h2AAA, 15'h5555, 15'h2AAA, 15'h001F, 15'h5555, FRAME_CLEAN, 0, 0, 0);

        frames = 0;
        while (words_sent < WORD_TARGET) begin
            if (words_sent >= WORD_TARGET - QUIET_TAIL) begin
                gap_pct = 0;
                stall_pct <= 0;
            end else if (frames % 10 == 0) begin
                pick = $urandom_range(0, 3);
                gap_pct = (pick == 0) ? 0 : (pick == 1) ? 5 : (pick == 2) ? 20 : 50;
                pick = $urandom_range(0, 3);
                stall_pct <= (pick == 0) ? 0 : (pick == 1) ? 5 : (pick == 2) ? 20 : 50;
            end
            if (frames == 40) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (outstanding != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 3)) send_word(16'($urandom_range(0, 65535)));
            end
            pick = $urandom_range(0, 9);
            fault = (pick < 7) ? FRAME_CLEAN : (pick == 7) ? FRAME_BAD_CHECK
                  : (pick == 8) ? FRAME_FLAGGED : FRAME_NO_END;
            send_frame(body_value(), body_value(), body_value(), body_value(), body_value(),
                       fault, $urandom_range(1, 6),
                       (fault == FRAME_FLAGGED) ? flagged_word() : wrong_end_word(),
                       ($urandom_range(0, 1) == 0) ? 0 : 10);
            frames++;
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/defp_pkg.sv
src/defp_decoder.sv
src/detector_event_frame_parser_core.sv
test/detector_event_frame_parser_checker.sv
test/detector_event_frame_parser_core_tb.sv
